### design/pkf_pkg.sv
// Shared types and constants for the position Kalman filter.
`default_nettype none

package pkf_pkg;

    // Variance and noise registers are unsigned Q15.16 held in 31 bits.
    localparam int VAR_W = 31;
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    // Sum of predicted variance and measurement noise needs one more bit.
    localparam int SUM_W = VAR_W + 1;

    // Reset values of the configuration registers.
    localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = 31'd655;
    localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 31'd3277;
    localparam logic [VAR_W-1:0] INITIAL_VARIANCE_RST  = 31'd65536;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE  = 2'd2;

    // Three filtered channels: x, y and heading.
    localparam int CHAN_NUM = 3;
    localparam int CHAN_W = 2;
    localparam logic [CHAN_W-1:0] CHAN_FIRST = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_LAST  = 2'd2;

    // Multiplier operand slice taken per cycle by the shared unit.
    localparam int CHUNK_W = 16;

    // Top-level sequencer states.
    typedef enum logic [6:0] {
        SEQ_IDLE     = 7'b0000001,
        SEQ_PRED     = 7'b0000010,
        SEQ_CH_GO    = 7'b0000100,
        SEQ_CH_WAIT  = 7'b0001000,
        SEQ_VAR_GO   = 7'b0010000,
        SEQ_VAR_WAIT = 7'b0100000,
        SEQ_FIN      = 7'b1000000
    } seq_state_t;

    // Multiply-divide unit states.
    typedef enum logic [3:0] {
        MDV_IDLE = 4'b0001,
        MDV_MUL  = 4'b0010,
        MDV_RND  = 4'b0100,
        MDV_DIV  = 4'b1000
    } mdv_state_t;

endpackage : pkf_pkg

`default_nettype wire

### design/pkf_muldiv.sv
// Shared multiply-divide unit: quot = floor((a * b + s/2) / s), one radix-2 step per cycle.
`default_nettype none

module pkf_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   start,
    input  wire logic [pkf_pkg::VAR_W-1:0]              op_a,
    input  wire logic [((DATA_WIDTH + 1 > pkf_pkg::VAR_W) ?
                        DATA_WIDTH + 1 : pkf_pkg::VAR_W)-1:0] op_b,
    input  wire logic [pkf_pkg::SUM_W-1:0]              op_s,
    output logic                                        done,
    output logic [((DATA_WIDTH + 1 > pkf_pkg::VAR_W) ?
                   DATA_WIDTH + 1 : pkf_pkg::VAR_W)-1:0] quot
);

    // Operand and quotient width, multiplier slicing and accumulator width.
    localparam int MW   = (DATA_WIDTH + 1 > pkf_pkg::VAR_W) ? DATA_WIDTH + 1 : pkf_pkg::VAR_W;
    localparam int CW   = pkf_pkg::CHUNK_W;
    localparam int NCH  = (MW + CW - 1) / CW;
    localparam int BW   = NCH * CW;
    localparam int NW   = BW + pkf_pkg::SUM_W;
    localparam int QW   = MW;
    localparam int PW   = pkf_pkg::VAR_W + CW;
    localparam int SW   = pkf_pkg::SUM_W;
    localparam int CNTW = $clog2(QW + 1);
    localparam logic [CNTW-1:0] MUL_LAST = CNTW'(NCH - 1);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(QW - 1);

    pkf_pkg::mdv_state_t state_reg;
    logic [pkf_pkg::VAR_W-1:0] a_reg;
    logic [BW-1:0]             b_reg;
    logic [SW-1:0]             s_reg;
    logic [NW-1:0]             acc_reg;
    logic [SW-1:0]             rem_reg;
    logic [QW-1:0]             lo_reg;
    logic [QW-1:0]             q_reg;
    logic [CNTW-1:0]           cnt_reg;
    logic                      done_reg;

    logic [PW-1:0] prod;
    logic [NW-1:0] acc_next;
    logic [NW-1:0] rnd_sum;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          fits;

    // One slice of b per cycle, most significant slice first.
    always_comb begin
        prod     = a_reg * b_reg[BW-1 -: CW];
        acc_next = (acc_reg << CW) + NW'(prod);
        rnd_sum  = acc_reg + NW'(s_reg >> 1);
        trial    = {rem_reg, lo_reg[QW-1]};
        diff     = trial - {1'b0, s_reg};
        fits     = (trial >= {1'b0, s_reg});
    end

    // Sequencer: multiply, add the rounding half, then restoring division.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pkf_pkg::MDV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                pkf_pkg::MDV_IDLE: begin
                    if (start) begin
                        a_reg     <= op_a;
                        b_reg     <= BW'(op_b);
                        s_reg     <= op_s;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= pkf_pkg::MDV_MUL;
                    end
                end
                pkf_pkg::MDV_MUL: begin
                    acc_reg <= acc_next;
                    b_reg   <= b_reg << CW;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= pkf_pkg::MDV_RND;
                    end
                end
                pkf_pkg::MDV_RND: begin
                    // The quotient fits QW bits, so the bits above QW are below s.
                    rem_reg   <= rnd_sum[QW +: SW];
                    lo_reg    <= rnd_sum[QW-1:0];
                    cnt_reg   <= '0;
                    state_reg <= pkf_pkg::MDV_DIV;
                end
                pkf_pkg::MDV_DIV: begin
                    rem_reg <= fits ? diff[SW-1:0] : trial[SW-1:0];
                    q_reg   <= {q_reg[QW-2:0], fits};
                    lo_reg  <= lo_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST) begin
                        done_reg  <= 1'b1;
                        state_reg <= pkf_pkg::MDV_IDLE;
                    end
                end
                default: begin
                    state_reg <= pkf_pkg::MDV_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule : pkf_muldiv

`default_nettype wire

### design/position_kalman_filter_unit.sv
// Top level of the constant-position Kalman filter over x, y and heading.
//
// Usage: measurement triples arrive on the s_ stream (tdata holds meas_x,
// meas_y, meas_heading). Each accepted transfer yields exactly one transfer
// on the m_ stream carrying the three estimates and the shared variance in
// tdata and the first-sample flag in tuser. The noise and initial variance
// registers are written through the cfg_ port; the user must write them only
// while the block is idle, as the block itself does not enforce this. The
// first sample after reset only loads the estimate. Every later sample takes
// a prediction step plus four passes through the shared multiply-divide unit
// (three corrections and the new variance); if the innovation variance is
// zero, the passes are skipped, the estimates stay and the variance is
// cleared. s_tready is high only while no item is in work. The result waits
// in an output register; if the receiver stalls, the block can still take
// the next item and holds its result until the register is free. Reset
// clears the estimates, loads the register defaults and drops m_tvalid.
`default_nettype none

module position_kalman_filter_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input stream. tdata: meas_x, meas_y, meas_heading (lowest first).
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((3*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // Result stream. tdata: est_x, est_y, est_heading, est_variance (lowest first).
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((3*DATA_WIDTH + pkf_pkg::VAR_W + 7) / 8) * 8 - 1:0] m_tdata,
    // tuser: first_sample.
    output logic [0:0]                                 m_tuser,
    // Configuration write port.
    input  wire logic                                  cfg_we,
    input  wire logic [pkf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [pkf_pkg::VAR_W-1:0]             cfg_wdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int VW    = pkf_pkg::VAR_W;
    localparam int SW    = pkf_pkg::SUM_W;
    localparam int MW    = (DW + 1 > VW) ? DW + 1 : VW;
    localparam int OUT_W = ((3*DW + VW + 7) / 8) * 8;
    localparam logic signed [DW-1:0] EST_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] EST_MIN = {1'b1, {(DW-1){1'b0}}};

    pkf_pkg::seq_state_t state_reg;

    logic [VW-1:0] pnoise_reg;
    logic [VW-1:0] mnoise_reg;
    logic [VW-1:0] var_reg;
    logic          started_reg;

    logic signed [DW-1:0] est_reg [pkf_pkg::CHAN_NUM];
    logic signed [DW-1:0] z_reg   [pkf_pkg::CHAN_NUM];

    logic [VW-1:0]                 pp_reg;
    logic [SW-1:0]                 s_reg;
    logic [pkf_pkg::CHAN_W-1:0]    ch_reg;
    logic                          neg_reg;
    logic                          first_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    logic             in_xfer;
    logic             out_free;
    logic [SW-1:0]    pred_sum;
    logic [VW-1:0]    pp_next;
    logic [SW-1:0]    s_next;
    logic signed [DW:0]   delta;
    logic [DW:0]          mag;
    logic signed [DW+1:0] est_wide;
    logic signed [DW+1:0] corr_wide;
    logic signed [DW+1:0] upd_wide;
    logic signed [DW-1:0] est_next;
    logic [VW-1:0]        var_next;
    logic [OUT_W-1:0]     m_tdata_next;

    logic          mdv_start;
    logic [MW-1:0] mdv_b;
    logic          mdv_done;
    logic [MW-1:0] mdv_quot;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == pkf_pkg::SEQ_IDLE);

    // Predicted variance with saturation, and the innovation variance.
    always_comb begin
        pred_sum = {1'b0, var_reg} + {1'b0, pnoise_reg};
        pp_next  = pred_sum[SW-1] ? pkf_pkg::VAR_MAX : pred_sum[VW-1:0];
        s_next   = {1'b0, pp_next} + {1'b0, mnoise_reg};
    end

    // Innovation of the current channel, split into sign and magnitude.
    always_comb begin
        delta = {z_reg[ch_reg][DW-1], z_reg[ch_reg]} - {est_reg[ch_reg][DW-1], est_reg[ch_reg]};
        mag   = delta[DW] ? (DW+1)'(-delta) : (DW+1)'(delta);
    end

    // Apply the signed correction and saturate to the estimate range.
    always_comb begin
        est_wide  = {{2{est_reg[ch_reg][DW-1]}}, est_reg[ch_reg]};
        corr_wide = {1'b0, mdv_quot[DW:0]};
        upd_wide  = neg_reg ? est_wide - corr_wide : est_wide + corr_wide;
        if ((upd_wide[DW+1:DW-1] == 3'b000) || (upd_wide[DW+1:DW-1] == 3'b111)) begin
            est_next = upd_wide[DW-1:0];
        end else if (upd_wide[DW+1]) begin
            est_next = EST_MIN;
        end else begin
            est_next = EST_MAX;
        end
        // The new variance never exceeds the predicted one, so it fits the register.
        var_next = mdv_quot[VW-1:0];
    end

    // Shared unit operands: channel magnitude or measurement noise.
    assign mdv_start = (state_reg == pkf_pkg::SEQ_CH_GO) || (state_reg == pkf_pkg::SEQ_VAR_GO);
    assign mdv_b     = (state_reg == pkf_pkg::SEQ_VAR_GO) ? MW'(mnoise_reg) : MW'(mag);

    pkf_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mdv_start),
        .op_a    (pp_reg),
        .op_b    (mdv_b),
        .op_s    (s_reg),
        .done    (mdv_done),
        .quot    (mdv_quot)
    );

    // Result word packing.
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[0*DW +: DW] = est_reg[0];
        m_tdata_next[1*DW +: DW] = est_reg[1];
        m_tdata_next[2*DW +: DW] = est_reg[2];
        m_tdata_next[3*DW +: VW] = var_reg;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pnoise_reg <= pkf_pkg::PROCESS_NOISE_RST;
            mnoise_reg <= pkf_pkg::MEASUREMENT_NOISE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pkf_pkg::REG_PROCESS_NOISE:     pnoise_reg <= cfg_wdata;
                pkf_pkg::REG_MEASUREMENT_NOISE: mnoise_reg <= cfg_wdata;
                pkf_pkg::REG_INITIAL_VARIANCE: begin
                    // Only matters before the first sample; the sequencer loads it.
                end
                default: begin
                end
            endcase
        end
    end

    // Filter sequencer and state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pkf_pkg::SEQ_IDLE;
            started_reg  <= 1'b0;
            var_reg      <= pkf_pkg::INITIAL_VARIANCE_RST;
            est_reg[0]   <= '0;
            est_reg[1]   <= '0;
            est_reg[2]   <= '0;
            ch_reg       <= pkf_pkg::CHAN_FIRST;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A taken result frees the output register unless a new one moves in.
            if (m_tvalid_reg && m_tready && (state_reg != pkf_pkg::SEQ_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            // Before the first sample, a new initial variance also loads the estimate's.
            if (cfg_we && (cfg_index == pkf_pkg::REG_INITIAL_VARIANCE) && !started_reg) begin
                var_reg <= cfg_wdata;
            end
            unique case (state_reg)
                pkf_pkg::SEQ_IDLE: begin
                    if (in_xfer) begin
                        z_reg[0] <= s_tdata[0*DW +: DW];
                        z_reg[1] <= s_tdata[1*DW +: DW];
                        z_reg[2] <= s_tdata[2*DW +: DW];
                        if (!started_reg) begin
                            est_reg[0]  <= s_tdata[0*DW +: DW];
                            est_reg[1]  <= s_tdata[1*DW +: DW];
                            est_reg[2]  <= s_tdata[2*DW +: DW];
                            started_reg <= 1'b1;
                            first_reg   <= 1'b1;
                            state_reg   <= pkf_pkg::SEQ_FIN;
                        end else begin
                            first_reg <= 1'b0;
                            state_reg <= pkf_pkg::SEQ_PRED;
                        end
                    end
                end
                pkf_pkg::SEQ_PRED: begin
                    pp_reg <= pp_next;
                    s_reg  <= s_next;
                    ch_reg <= pkf_pkg::CHAN_FIRST;
                    if (s_next == '0) begin
                        // No variance at all: the gain is zero, estimates stay.
                        var_reg   <= '0;
                        state_reg <= pkf_pkg::SEQ_FIN;
                    end else begin
                        state_reg <= pkf_pkg::SEQ_CH_GO;
                    end
                end
                pkf_pkg::SEQ_CH_GO: begin
                    neg_reg   <= delta[DW];
                    state_reg <= pkf_pkg::SEQ_CH_WAIT;
                end
                pkf_pkg::SEQ_CH_WAIT: begin
                    if (mdv_done) begin
                        est_reg[ch_reg] <= est_next;
                        if (ch_reg == pkf_pkg::CHAN_LAST) begin
                            state_reg <= pkf_pkg::SEQ_VAR_GO;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= pkf_pkg::SEQ_CH_GO;
                        end
                    end
                end
                pkf_pkg::SEQ_VAR_GO: begin
                    state_reg <= pkf_pkg::SEQ_VAR_WAIT;
                end
                pkf_pkg::SEQ_VAR_WAIT: begin
                    if (mdv_done) begin
                        var_reg   <= var_next;
                        state_reg <= pkf_pkg::SEQ_FIN;
                    end
                end
                pkf_pkg::SEQ_FIN: begin
                    // Hand the result over once the output register is free.
                    if (out_free) begin
                        m_tdata_reg  <= m_tdata_next;
                        m_tuser_reg  <= first_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= pkf_pkg::SEQ_IDLE;
                    end
                end
                default: begin
                    state_reg <= pkf_pkg::SEQ_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule : position_kalman_filter_unit

`default_nettype wire

### design/pkf_checker.sv
// Port-level checker for the position Kalman filter, bound to the top level.
`default_nettype none

module pkf_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tvalid,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((3*DATA_WIDTH + pkf_pkg::VAR_W + 7) / 8) * 8 - 1:0] m_tdata,
    input wire logic [0:0]                            m_tuser
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or was dropped");

    // After a transfer in, the block is busy with that item.
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an item is in work");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A new result only shows up when the block returns to idle.
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result presented while an item is still in work");

endmodule : pkf_checker

bind position_kalman_filter_unit pkf_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pkf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
